/* src/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define SMIE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define SMIE_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

/* src/smie_pkg.sv */
package smie_pkg;

  localparam int unsigned OpcodeW = 2;
  localparam int unsigned ResKeyW = 64;

  localparam logic [OpcodeW-1:0] OpLoadA = 2'd0;
  localparam logic [OpcodeW-1:0] OpLoadB = 2'd1;
  localparam logic [OpcodeW-1:0] OpRun   = 2'd2;

  localparam logic ModeMerge     = 1'b0;
  localparam logic ModeIntersect = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FETCH,
    ST_CMP,
    ST_FLUSH
  } state_e;

  typedef struct packed {
    logic load_a;
    logic load_b;
    logic adv_a;
    logic adv_b;
    logic push;
    logic sel_b;
    logic flush;
  } dp_cmd_t;

  typedef struct packed {
    logic a_more;
    logic b_more;
    logic a_lt_b;
    logic a_eq_b;
  } dp_status_t;

endpackage

/* src/sorted_merge_intersect_engine_top.sv */
// Two sorted key lists A and B are loaded with start and opcode load A or load B, one key per
// transaction. A run transaction walks both lists and emits one key per result strobe
// (res_valid_o), the last marked by last_o; an empty output gives a single result with
// empty_res_o set. Each cursor step is a registered list read (FETCH) followed by a compare
// (CMP); in intersect mode the run ends as soon as either list is exhausted. busy stays
// high for the whole run. Results are shown for exactly one cycle and cannot be stalled by
// the receiver. The mode register is written with cfg_we_i.

module sorted_merge_intersect_engine_top #(
  parameter int unsigned LIST_DEPTH = 32,
  parameter int unsigned KEY_WIDTH  = 64
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start,
  output logic                              busy,
  input  logic [smie_pkg::OpcodeW-1:0]      opcode_i,
  input  logic signed [smie_pkg::ResKeyW-1:0] key_i,
  input  logic                              cfg_we_i,
  input  logic                              cfg_wdata_i,
  output logic                              res_valid_o,
  output logic signed [smie_pkg::ResKeyW-1:0] key_res_o,
  output logic                              last_o,
  output logic                              empty_res_o,
  output logic                              overflow_o
);

  smie_pkg::dp_cmd_t    cmd;
  smie_pkg::dp_status_t status;

  smie_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .opcode_i    (opcode_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .status_i    (status),
    .cmd_o       (cmd),
    .busy_o      (busy)
  );

  smie_dp #(
    .LIST_DEPTH (LIST_DEPTH),
    .KEY_WIDTH  (KEY_WIDTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .key_i       (key_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .res_valid_o (res_valid_o),
    .key_res_o   (key_res_o),
    .last_o      (last_o),
    .empty_res_o (empty_res_o),
    .overflow_o  (overflow_o)
  );

endmodule

/* src/smie_ctrl.sv */
`include "assert_macros.svh"

module smie_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  input  logic [smie_pkg::OpcodeW-1:0]        opcode_i,
  input  logic                                cfg_we_i,
  input  logic                                cfg_wdata_i,
  input  smie_pkg::dp_status_t                status_i,
  output smie_pkg::dp_cmd_t                   cmd_o,
  output logic                                busy_o
);

  smie_pkg::state_e state_q, state_d;
  logic             mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= smie_pkg::ST_IDLE;
      mode_q  <= smie_pkg::ModeMerge;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      smie_pkg::ST_IDLE: begin
        if (start) begin
          case (opcode_i)
            smie_pkg::OpLoadA: cmd_o.load_a = 1'b1;
            smie_pkg::OpLoadB: cmd_o.load_b = 1'b1;
            smie_pkg::OpRun:   state_d = smie_pkg::ST_FETCH;
            default: ;
          endcase
        end
      end
      smie_pkg::ST_FETCH: begin
        if (mode_q == smie_pkg::ModeMerge) begin
          if (status_i.a_more || status_i.b_more) begin
            state_d = smie_pkg::ST_CMP;
          end else begin
            state_d = smie_pkg::ST_FLUSH;
          end
        end else begin
          if (status_i.a_more && status_i.b_more) begin
            state_d = smie_pkg::ST_CMP;
          end else begin
            state_d = smie_pkg::ST_FLUSH;
          end
        end
      end
      smie_pkg::ST_CMP: begin
        state_d = smie_pkg::ST_FETCH;
        if (mode_q == smie_pkg::ModeMerge) begin
          cmd_o.push  = 1'b1;
          cmd_o.sel_b = !(status_i.a_more && (!status_i.b_more || status_i.a_lt_b));
          cmd_o.adv_a = !cmd_o.sel_b;
          cmd_o.adv_b = cmd_o.sel_b;
        end else if (status_i.a_eq_b) begin
          cmd_o.push  = 1'b1;
          cmd_o.adv_a = 1'b1;
          cmd_o.adv_b = 1'b1;
        end else if (status_i.a_lt_b) begin
          cmd_o.adv_a = 1'b1;
        end else begin
          cmd_o.adv_b = 1'b1;
        end
      end
      smie_pkg::ST_FLUSH: begin
        cmd_o.flush = 1'b1;
        state_d     = smie_pkg::ST_IDLE;
      end
      default: state_d = smie_pkg::ST_IDLE;
    endcase
  end

  assign busy_o = (state_q != smie_pkg::ST_IDLE);

  `SMIE_ASSERT_NXT(cmp_then_fetch, clk_i, rst_ni, state_q == smie_pkg::ST_CMP,
                   state_q == smie_pkg::ST_FETCH)
  `SMIE_ASSERT_IMP(step_moves_cursor, clk_i, rst_ni, state_q == smie_pkg::ST_CMP,
                   cmd_o.adv_a || cmd_o.adv_b)

endmodule

/* src/smie_dp.sv */
`include "assert_macros.svh"

module smie_dp #(
  parameter int unsigned LIST_DEPTH = 32,
  parameter int unsigned KEY_WIDTH  = 64
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic [smie_pkg::ResKeyW-1:0]     key_i,
  input  smie_pkg::dp_cmd_t                cmd_i,
  output smie_pkg::dp_status_t             status_o,
  output logic                             res_valid_o,
  output logic [smie_pkg::ResKeyW-1:0]     key_res_o,
  output logic                             last_o,
  output logic                             empty_res_o,
  output logic                             overflow_o
);

  localparam int unsigned CntW = $clog2(LIST_DEPTH + 1);
  localparam int unsigned IdxW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam logic [CntW-1:0] Full = CntW'(LIST_DEPTH);

  logic [KEY_WIDTH-1:0] mem_a [LIST_DEPTH];
  logic [KEY_WIDTH-1:0] mem_b [LIST_DEPTH];
  logic [KEY_WIDTH-1:0] rd_a_q, rd_b_q;

  logic [CntW-1:0] cnt_a_q, cnt_b_q, ia_q, ib_q;
  logic            dropped_q;
  logic            pend_vld_q;
  logic [KEY_WIDTH-1:0] pend_key_q;
  logic            res_valid_q, res_last_q, res_empty_q, res_ovf_q;
  logic [KEY_WIDTH-1:0] res_key_q;
  logic [KEY_WIDTH-1:0] new_key;

  // list stores with registered read at the cursors
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_a && (cnt_a_q != Full)) begin
      mem_a[cnt_a_q[IdxW-1:0]] <= key_i[KEY_WIDTH-1:0];
    end
    if (cmd_i.load_b && (cnt_b_q != Full)) begin
      mem_b[cnt_b_q[IdxW-1:0]] <= key_i[KEY_WIDTH-1:0];
    end
    rd_a_q <= mem_a[ia_q[IdxW-1:0]];
    rd_b_q <= mem_b[ib_q[IdxW-1:0]];
  end

  assign status_o.a_more = (ia_q < cnt_a_q);
  assign status_o.b_more = (ib_q < cnt_b_q);
  assign status_o.a_lt_b = ($signed(rd_a_q) < $signed(rd_b_q));
  assign status_o.a_eq_b = (rd_a_q == rd_b_q);

  assign new_key = cmd_i.sel_b ? rd_b_q : rd_a_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q     <= '0;
      cnt_b_q     <= '0;
      ia_q        <= '0;
      ib_q        <= '0;
      dropped_q   <= 1'b0;
      pend_vld_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      if (cmd_i.load_a) begin
        if (cnt_a_q != Full) begin
          cnt_a_q <= cnt_a_q + CntW'(1);
        end else begin
          dropped_q <= 1'b1;
        end
      end
      if (cmd_i.load_b) begin
        if (cnt_b_q != Full) begin
          cnt_b_q <= cnt_b_q + CntW'(1);
        end else begin
          dropped_q <= 1'b1;
        end
      end
      if (cmd_i.adv_a) begin
        ia_q <= ia_q + CntW'(1);
      end
      if (cmd_i.adv_b) begin
        ib_q <= ib_q + CntW'(1);
      end
      // hold one result back so the final one can carry last
      if (cmd_i.push) begin
        pend_vld_q <= 1'b1;
        if (pend_vld_q) begin
          res_valid_q <= 1'b1;
        end
      end
      if (cmd_i.flush) begin
        res_valid_q <= 1'b1;
        pend_vld_q  <= 1'b0;
        cnt_a_q     <= '0;
        cnt_b_q     <= '0;
        ia_q        <= '0;
        ib_q        <= '0;
        dropped_q   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      pend_key_q  <= new_key;
      res_key_q   <= pend_key_q;
      res_last_q  <= 1'b0;
      res_empty_q <= 1'b0;
      res_ovf_q   <= dropped_q;
    end
    if (cmd_i.flush) begin
      res_key_q   <= pend_vld_q ? pend_key_q : '0;
      res_last_q  <= 1'b1;
      res_empty_q <= !pend_vld_q;
      res_ovf_q   <= dropped_q;
    end
  end

  assign res_valid_o = res_valid_q;
  assign key_res_o   = smie_pkg::ResKeyW'(signed'(res_key_q));
  assign last_o      = res_last_q;
  assign empty_res_o = res_empty_q;
  assign overflow_o  = res_ovf_q;

  `SMIE_ASSERT_IMP(cnt_a_bound, clk_i, rst_ni, 1'b1, (cnt_a_q <= Full) && (ia_q <= cnt_a_q))
  `SMIE_ASSERT_IMP(cnt_b_bound, clk_i, rst_ni, 1'b1, (cnt_b_q <= Full) && (ib_q <= cnt_b_q))
  `SMIE_ASSERT_IMP(empty_is_last, clk_i, rst_ni, res_valid_q && res_empty_q,
                   res_last_q && (res_key_q == '0))

endmodule
